// ===== src/mmf_pkg.sv =====
// Shared constants and controller/datapath interface types for the median filter.
package mmf_pkg;

  localparam int unsigned OffsetW    = 12;
  localparam int unsigned NumOffsets = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned ChanW      = 2;
  localparam int unsigned RawW       = 16;
  localparam int unsigned SampleW    = 18;
  localparam int unsigned TdataInW   = 24;
  localparam int unsigned TuserInW   = 2;
  localparam int unsigned TdataOutW  = 24;

  // Controller to datapath
  typedef struct packed {
    logic take;      // latch the incoming transaction
    logic check;     // apply a clear item to its channel
    logic wr;        // write the corrected sample, advance pointer and count
    logic rd;        // read one window entry, step the index
    logic rank;      // rank one window entry, step the index
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_sample; // valid channel, sample item, no timeout
    logic last;      // index is at the last filled entry
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// ===== src/mmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmf_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 20
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mmf_ctrl.sv =====
// Sequencing state machine for the median filter.
module mmf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mmf_pkg::sts_t sts_i,
  output mmf_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_RANK   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.is_sample ? ST_WRITE : ST_FINISH;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last) begin
          state_d = ST_WAIT;
        end
      end
      // last read data lands in the window this cycle
      ST_WAIT: begin
        state_d = ST_RANK;
      end
      ST_RANK: begin
        cmd_o.rank = 1'b1;
        if (sts_i.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded into a full output register");

  a_take_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> (state_q == ST_CHECK))
    else $error("accepted transaction not followed by decode");

endmodule

// ===== src/mmf_dp.sv =====
// Datapath: offsets, per-channel pointers and counts, window RAM, rank unit, output register.
module mmf_dp #(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned WINDOW   = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mmf_pkg::OffsetW-1:0]       cfg_wdata_i,
  input  logic [mmf_pkg::TdataInW-1:0]      in_data_i,
  input  logic [mmf_pkg::TuserInW-1:0]      in_user_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mmf_pkg::TdataOutW-1:0]     out_data_o,
  output logic                              out_user_o,
  input  mmf_pkg::cmd_t                     cmd_i,
  output mmf_pkg::sts_t                     sts_o
);

  localparam int unsigned PtrW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW    = $clog2(WINDOW + 1);
  localparam int unsigned ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Depth   = CHANNELS * WINDOW;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SampleW = mmf_pkg::SampleW;
  localparam int unsigned OffsetW = mmf_pkg::OffsetW;

  // latched transaction
  logic                        op_q, to_q;
  logic [mmf_pkg::ChanW-1:0]   ch_q;
  logic [mmf_pkg::RawW-1:0]    raw_q;

  logic [OffsetW-1:0]          off_q [mmf_pkg::NumOffsets];
  logic [PtrW-1:0]             ptr_q [CHANNELS];
  logic [CntW-1:0]             cnt_q [CHANNELS];

  logic [PtrW-1:0]             idx_q;
  logic                        rd_vld_q;
  logic [PtrW-1:0]             rd_idx_q;
  logic signed [SampleW-1:0]   win_q [WINDOW];
  logic signed [SampleW-1:0]   med_q;

  logic                        out_valid_q;
  logic signed [SampleW-1:0]   out_med_q;
  logic                        out_nr_q;

  logic                        ch_ok;
  logic [ChIdxW-1:0]           ch_sel;
  logic [PtrW-1:0]             ptr_sel, ptr_nxt;
  logic [CntW-1:0]             cnt_sel;
  logic signed [SampleW-1:0]   corr;
  logic [AddrW-1:0]            base, waddr, raddr;
  logic [SampleW-1:0]          rdata;
  logic signed [SampleW-1:0]   cand;
  logic [CntW-1:0]             rank;
  logic                        idx_last;

  assign ch_ok   = ({1'b0, ch_q} < 3'(CHANNELS));
  assign ch_sel  = ch_q[ChIdxW-1:0];
  assign ptr_sel = ptr_q[ch_sel];
  assign cnt_sel = cnt_q[ch_sel];
  assign ptr_nxt = (ptr_sel == PtrW'(WINDOW - 1)) ? '0 : ptr_sel + PtrW'(1);

  assign corr = $signed({2'b00, raw_q})
              - $signed({{(SampleW - OffsetW){off_q[ch_q][OffsetW-1]}}, off_q[ch_q]});

  assign base  = AddrW'(ch_sel) * AddrW'(WINDOW);
  assign waddr = base + AddrW'(ptr_sel);
  assign raddr = base + AddrW'(idx_q);

  assign idx_last = (CntW'(idx_q) == cnt_sel - CntW'(1));

  mmf_ram #(
    .WIDTH (SampleW),
    .DEPTH (Depth)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (waddr),
    .wdata_i (corr),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // rank with ties broken by position, so ranks form a permutation
  always_comb begin
    cand = win_q[idx_q];
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((CntW'(j) < cnt_sel) &&
          ((win_q[j] < cand) || ((win_q[j] == cand) && (PtrW'(j) < idx_q)))) begin
        rank = rank + CntW'(1);
      end
    end
  end

  assign sts_o.is_sample = ch_ok && !op_q && !to_q;
  assign sts_o.last      = idx_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= in_user_i[0];
      to_q  <= in_user_i[1];
      ch_q  <= in_data_i[mmf_pkg::ChanW-1:0];
      raw_q <= in_data_i[mmf_pkg::ChanW +: mmf_pkg::RawW];
    end
    if (rd_vld_q) begin
      win_q[rd_idx_q] <= $signed(rdata);
    end
    if (cmd_i.rd) begin
      rd_idx_q <= idx_q;
    end
    if (cmd_i.rank && (rank == (cnt_sel >> 1))) begin
      med_q <= cand;
    end
    if (cmd_i.load_out) begin
      out_med_q <= sts_o.is_sample ? med_q : '0;
      out_nr_q  <= !sts_o.is_sample;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmf_pkg::NumOffsets; i++) begin
        off_q[i] <= '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c] <= '0;
        cnt_q[c] <= '0;
      end
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        off_q[cfg_idx_i] <= cfg_wdata_i;
      end
      if (cmd_i.check && ch_ok && op_q) begin
        ptr_q[ch_sel] <= '0;
        cnt_q[ch_sel] <= '0;
      end
      if (cmd_i.wr) begin
        ptr_q[ch_sel] <= ptr_nxt;
        if (cnt_sel < CntW'(WINDOW)) begin
          cnt_q[ch_sel] <= cnt_sel + CntW'(1);
        end
        idx_q <= '0;
      end
      if (cmd_i.rd || cmd_i.rank) begin
        idx_q <= idx_last ? '0 : idx_q + PtrW'(1);
      end
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(mmf_pkg::TdataOutW - SampleW){1'b0}}, out_med_q};
  assign out_user_o  = out_nr_q;

  a_window_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rank |-> !rd_vld_q)
    else $error("ranking started before the window finished loading");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd || cmd_i.rank) |-> (cnt_sel != '0) && (cnt_sel <= CntW'(WINDOW)))
    else $error("fill count out of range during a window pass");

  a_no_reading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_nr_q) |-> (out_med_q == '0))
    else $error("no-reading result carries a non-zero distance");

endmodule

// ===== src/multichannel_median_filter.sv =====
// Multichannel running median filter for distance sensors: top level.
//
// Input stream (s_axis): one transaction per sample or clear item. tdata carries
// the channel and the raw reading in mm; tuser carries the op code and the
// timeout flag. Output stream (m_axis): exactly one result per input, in order;
// tdata carries the upper median of the channel's window, tuser the no-reading
// flag (timeout, clear item or unused channel; the distance is then zero).
// Offsets per channel are written through cfg_*; the user must write them only while
// the block is idle, which the block itself does not enforce. A sample item is
// written to the channel's window, whose filled entries are then read from the
// window RAM one entry per cycle, followed by one rank evaluation per cycle;
// clear, timeout and unused-channel items skip the window pass.
// The result is registered; a stalled receiver holds it while the next item is
// accepted and worked on, and only the final hand-off waits for the output
// register to free up. Reset clears offsets, pointers and fill counts; window
// contents are left as they are and never read unwritten.
module multichannel_median_filter #(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned WINDOW   = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mmf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mmf_pkg::OffsetW-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mmf_pkg::TdataInW-1:0]     s_axis_tdata,  // channel[1:0], raw_mm[17:2], zeros
  input  logic [mmf_pkg::TuserInW-1:0]     s_axis_tuser,  // op[0], timed_out[1]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mmf_pkg::TdataOutW-1:0]    m_axis_tdata,  // median_mm[17:0], zeros
  output logic                             m_axis_tuser   // no_reading[0]
);

  mmf_pkg::cmd_t cmd;
  mmf_pkg::sts_t sts;

  mmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmf_dp #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== verif/mmf_check_pkg.sv =====
// Scoreboard and item types for checking the multichannel median filter.
package mmf_check_pkg;

  import mmf_pkg::*;

  localparam int unsigned NumChan  = NumOffsets;
  localparam int unsigned WinDepth = 5;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef struct {
    op_e              op;
    logic [ChanW-1:0] channel;
    logic [RawW-1:0]  raw_mm;
    logic             timed_out;
  } sensor_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] median_mm;
    logic                      no_reading;
  } median_result_t;

  class median_scoreboard;
    int             window [NumChan][WinDepth];
    int unsigned    wr_ptr [NumChan];
    int unsigned    fill [NumChan];
    int             offset [NumChan];
    median_result_t pending_q [$];
    int unsigned    errors;
    int unsigned    results;
    int unsigned    samples;
    int unsigned    clears;
    int unsigned    timeouts;

    function new();
      foreach (wr_ptr[c]) begin
        wr_ptr[c] = 0;
        fill[c]   = 0;
        offset[c] = 0;
      end
      errors   = 0;
      results  = 0;
      samples  = 0;
      clears   = 0;
      timeouts = 0;
    endfunction

    function void set_offset(int unsigned ch, logic signed [OffsetW-1:0] value);
      offset[ch] = int'(value);
    endfunction

    // Update the channel's window and queue the result the block should return: the median, or no reading
    function void note_item(sensor_item_t it);
      median_result_t r;
      int             sorted [WinDepth];
      int             key;
      int             j;
      int unsigned    ch;
      int unsigned    n;
      ch           = it.channel;
      r.median_mm  = '0;
      r.no_reading = 1'b1;
      if (it.op == OP_CLEAR) begin
        wr_ptr[ch] = 0;
        fill[ch]   = 0;
        clears++;
      end else if (it.timed_out) begin
        timeouts++;
      end else begin
        window[ch][wr_ptr[ch]] = int'(it.raw_mm) - offset[ch];
        wr_ptr[ch] = (wr_ptr[ch] + 1 == WinDepth) ? 0 : wr_ptr[ch] + 1;
        if (fill[ch] < WinDepth) fill[ch]++;
        n = fill[ch];
        // insertion sort over the filled entries only
        for (int i = 0; i < int'(n); i++) begin
          key = window[ch][i];
          j   = i;
          while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = key;
        end
        r.median_mm  = SampleW'(sorted[n/2]);
        r.no_reading = 1'b0;
        samples++;
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [SampleW-1:0] median, logic none);
      median_result_t want;
      results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction: median_mm=%0d no_reading=%0b",
               $signed(median), none);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (median !== want.median_mm) begin
        $error("median_mm: expected %0d, actual %0d", want.median_mm, $signed(median));
        errors++;
      end
      if (none !== want.no_reading) begin
        $error("no_reading: expected %0b, actual %0b", want.no_reading, none);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== verif/multichannel_median_filter_test.sv =====
// Top-level testbench for the multichannel median filter.
module multichannel_median_filter_test;

  timeunit 1ns;
  timeprecision 1ps;

  import mmf_pkg::*;
  import mmf_check_pkg::*;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [OffsetW-1:0]   cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TdataInW-1:0]  s_axis_tdata  = '0;  // channel[1:0], raw_mm[17:2], zeros
  logic [TuserInW-1:0]  s_axis_tuser  = '0;  // op[0], timed_out[1]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata;        // median_mm[17:0], zeros
  logic                 m_axis_tuser;        // no_reading[0]

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned settings  = 0;
  logic signed [OffsetW-1:0] next_offset [NumChan];

  median_scoreboard sb = new();

  multichannel_median_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check each completed transaction, then pick next cycle's tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[SampleW-1:0], m_axis_tuser);
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_item(input op_e op, input logic [ChanW-1:0] ch,
                           input logic [RawW-1:0] raw, input logic timed_out);
    sensor_item_t it;
    it.op        = op;
    it.channel   = ch;
    it.raw_mm    = raw;
    it.timed_out = timed_out;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TdataInW - ChanW - RawW){1'b0}}, raw, ch};
    s_axis_tuser  <= {timed_out, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  // Offsets only change with the block idle
  task automatic apply_offsets();
    for (int i = 0; i < int'(NumChan); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgIdxW'(i);
      cfg_wdata_i <= next_offset[i];
      @(posedge clk_i);
      sb.set_offset(i, next_offset[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count);
    logic [ChanW-1:0] ch;
    logic [RawW-1:0]  raw;
    int unsigned      roll;
    ch = '0;
    for (int n = 0; n < int'(count); n++) begin
      // mostly runs on one channel so windows fill and wrap
      if ($urandom_range(9) >= 7) ch = ChanW'($urandom_range(NumChan - 1));
      case ($urandom_range(9))
        0:       raw = '0;
        1:       raw = '1;
        2, 3:    raw = RawW'($urandom_range(4095));
        default: raw = RawW'($urandom_range(65535));
      endcase
      roll = $urandom_range(99);
      if (roll < 4) begin
        push_item(OP_CLEAR, ch, raw, 1'($urandom_range(1)));
      end else if (roll < 12) begin
        push_item(OP_SAMPLE, ch, raw, 1'b1);
      end else begin
        push_item(OP_SAMPLE, ch, raw, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    next_offset[0] = -12'sd2048;
    next_offset[1] = 12'sd2047;
    next_offset[2] = 12'sd0;
    next_offset[3] = 12'sh555;
    apply_offsets();

    // extremes of the corrected range, window wrap, timeouts and clears
    push_item(OP_SAMPLE, 2'd0, 16'd0,     1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'hFFFF,  1'b0);
    push_item(OP_SAMPLE, 2'd1, 16'd0,     1'b0);
    push_item(OP_SAMPLE, 2'd1, 16'hFFFF,  1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'd0,     1'b1);
    push_item(OP_SAMPLE, 2'd0, 16'd1000,  1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'd500,   1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'd30000, 1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'd7,     1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'd7,     1'b0);
    push_item(OP_CLEAR,  2'd0, 16'd0,     1'b0);
    push_item(OP_SAMPLE, 2'd0, 16'd42,    1'b0);
    push_item(OP_CLEAR,  2'd1, 16'hFFFF,  1'b1);
    push_item(OP_SAMPLE, 2'd1, 16'd2047,  1'b0);
    push_item(OP_SAMPLE, 2'd2, 16'hAAAA,  1'b0);
    push_item(OP_SAMPLE, 2'd2, 16'h5555,  1'b0);
    push_item(OP_SAMPLE, 2'd3, 16'hFFFF,  1'b1);
    push_item(OP_SAMPLE, 2'd3, 16'd123,   1'b0);
    push_item(OP_CLEAR,  2'd3, 16'd0,     1'b0);
    push_item(OP_SAMPLE, 2'd3, 16'd0,     1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 31;
          stall_pct = 78;
          foreach (next_offset[c]) next_offset[c] = OffsetW'($urandom_range(4095));
        end
        1: begin
          idle_pct  = 78;
          stall_pct = 31;
          next_offset[0] = 12'sd2047;
          next_offset[1] = -12'sd2048;
          next_offset[2] = -12'sd1;
          next_offset[3] = 12'sd1;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
          foreach (next_offset[c]) next_offset[c] = OffsetW'($urandom_range(4095));
        end
      endcase
      apply_offsets();
      random_phase(545);
      drain();
    end

    $display("Checked %0d results: %0d samples, %0d clears, %0d timeouts.",
             sb.results, sb.samples, sb.clears, sb.timeouts);
    $display("Offset settings used: %0d; sender/receiver pressure profiles: 3.", settings);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mmf_pkg.sv
src/mmf_ram.sv
src/mmf_ctrl.sv
src/mmf_dp.sv
src/multichannel_median_filter.sv
verif/mmf_check_pkg.sv
verif/multichannel_median_filter_test.sv
